// File: sv/ipsp_pkg.sv
// Shared types, codes and constants for the IPS patch stream parser.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ipsp_pkg;

  localparam int unsigned AddrW  = 25;
  localparam int unsigned OffW   = 24;
  localparam int unsigned ShiftW = 16;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned OutDataW = 56;

  // Parse phases.
  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_OFF0   = 4'd1;
  localparam logic [3:0] PH_OFF1   = 4'd2;
  localparam logic [3:0] PH_OFF2   = 4'd3;
  localparam logic [3:0] PH_SIZE0  = 4'd4;
  localparam logic [3:0] PH_SIZE1  = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_RLEN0  = 4'd7;
  localparam logic [3:0] PH_RLEN1  = 4'd8;
  localparam logic [3:0] PH_RVAL   = 4'd9;

  // Result kinds.
  localparam logic [KindW-1:0] K_WRITE  = 3'd0;
  localparam logic [KindW-1:0] K_FILL   = 3'd1;
  localparam logic [KindW-1:0] K_END    = 3'd2;
  localparam logic [KindW-1:0] K_BADHDR = 3'd3;
  localparam logic [KindW-1:0] K_TRUNC  = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_R3_START = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_R2_START = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_R1_START = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_R0_START = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_R3_SHIFT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_R2_SHIFT = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_R1_SHIFT = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_R0_SHIFT = 3'd7;

  localparam logic [OffW-1:0] EOF_MARK = 24'h454F46;
  localparam logic [2:0] HDR_LEN = 3'd5;

  localparam logic [OffW-1:0] R3_START_RST = 24'h560C00;
  localparam logic [OffW-1:0] R2_START_RST = 24'h53E691;
  localparam logic [OffW-1:0] R1_START_RST = 24'h3BB800;
  localparam logic [OffW-1:0] R0_START_RST = 24'h000400;
  localparam logic [ShiftW-1:0] R3_SHIFT_RST = 16'h2400;
  localparam logic [ShiftW-1:0] R2_SHIFT_RST = 16'h1800;
  localparam logic [ShiftW-1:0] R1_SHIFT_RST = 16'h1800;
  localparam logic [ShiftW-1:0] R0_SHIFT_RST = 16'h0C00;

  // Region thresholds and shifts, indexed by region number.
  typedef struct packed {
    logic [3:0][OffW-1:0]   start;
    logic [3:0][ShiftW-1:0] shift;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] value;
    logic [LenW-1:0]  len;
  } result_t;

  // Expected header text "PATCH".
  function automatic logic [ByteW-1:0] hdr_char(input logic [2:0] idx);
    logic [ByteW-1:0] c;
    case (idx)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h43;
      3'd4:    c = 8'h48;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/ipsp_regs.sv
// Configuration registers: region thresholds and shifts.
// Depends on ipsp_pkg.
`default_nettype none

module ipsp_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ipsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ipsp_pkg::CfgDataW-1:0] cfg_data_i,
  output ipsp_pkg::cfg_t                     cfg_o
);

  ipsp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ipsp_pkg::CFG_R3_START: cfg_d.start[3] = cfg_data_i[ipsp_pkg::OffW-1:0];
        ipsp_pkg::CFG_R2_START: cfg_d.start[2] = cfg_data_i[ipsp_pkg::OffW-1:0];
        ipsp_pkg::CFG_R1_START: cfg_d.start[1] = cfg_data_i[ipsp_pkg::OffW-1:0];
        ipsp_pkg::CFG_R0_START: cfg_d.start[0] = cfg_data_i[ipsp_pkg::OffW-1:0];
        ipsp_pkg::CFG_R3_SHIFT: cfg_d.shift[3] = cfg_data_i[ipsp_pkg::ShiftW-1:0];
        ipsp_pkg::CFG_R2_SHIFT: cfg_d.shift[2] = cfg_data_i[ipsp_pkg::ShiftW-1:0];
        ipsp_pkg::CFG_R1_SHIFT: cfg_d.shift[1] = cfg_data_i[ipsp_pkg::ShiftW-1:0];
        ipsp_pkg::CFG_R0_SHIFT: cfg_d.shift[0] = cfg_data_i[ipsp_pkg::ShiftW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start[3] <= ipsp_pkg::R3_START_RST;
      cfg_q.start[2] <= ipsp_pkg::R2_START_RST;
      cfg_q.start[1] <= ipsp_pkg::R1_START_RST;
      cfg_q.start[0] <= ipsp_pkg::R0_START_RST;
      cfg_q.shift[3] <= ipsp_pkg::R3_SHIFT_RST;
      cfg_q.shift[2] <= ipsp_pkg::R2_SHIFT_RST;
      cfg_q.shift[1] <= ipsp_pkg::R1_SHIFT_RST;
      cfg_q.shift[0] <= ipsp_pkg::R0_SHIFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/ipsp_in_stage.sv
// Input register for the patch byte stream.
// Depends on ipsp_pkg.
`default_nettype none

module ipsp_in_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output      logic                       ready_o,
  input  wire logic [ipsp_pkg::ByteW-1:0] byte_i,
  input  wire logic                       last_i,
  input  wire logic                       advance_i,
  output      logic                       valid_o,
  output      logic [ipsp_pkg::ByteW-1:0] byte_o,
  output      logic                       last_o
);

  logic                       valid_q, valid_d;
  logic [ipsp_pkg::ByteW-1:0] byte_q;
  logic                       last_q;
  logic                       load;

  // The held byte leaves in the same cycle as a new one arrives.
  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// File: sv/ipsp_parser.sv
// Record parser: header check, offset and size fields, data and fill runs,
// and the region remap. Depends on ipsp_pkg.
`default_nettype none

module ipsp_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic [ipsp_pkg::ByteW-1:0] byte_i,
  input  wire logic                       last_i,
  input  ipsp_pkg::cfg_t                  cfg_i,
  output      logic                       res_vld_o,
  output ipsp_pkg::result_t               res_o
);

  logic [3:0]                  phase_q, phase_d;
  logic [2:0]                  hdr_idx_q, hdr_idx_d;
  logic [ipsp_pkg::OffW-1:0]   off_q, off_d;
  logic [ipsp_pkg::AddrW-1:0]  addr_q, addr_d;
  logic [ipsp_pkg::LenW-1:0]   left_q, left_d;
  logic [ipsp_pkg::LenW-1:0]   fill_q, fill_d;
  logic                        done_q, done_d;

  logic [ipsp_pkg::OffW-1:0]   off_new;
  logic [ipsp_pkg::LenW-1:0]   left_dec;
  logic [2:0]                  hdr_idx_inc;
  logic [ipsp_pkg::AddrW-1:0]  remapped;
  logic [ipsp_pkg::AddrW-1:0]  off_ext;

  assign off_new     = {off_q[ipsp_pkg::OffW-1:8], byte_i};
  assign left_dec    = left_q - 16'd1;
  assign hdr_idx_inc = hdr_idx_q + 3'd1;
  assign off_ext     = {1'b0, off_new};

  // Regions are tried from the highest down; the first match wins.
  always_comb begin
    if (off_new >= cfg_i.start[3]) begin
      remapped = off_ext + {9'd0, cfg_i.shift[3]};
    end else if (off_new >= cfg_i.start[2]) begin
      remapped = off_ext + {9'd0, cfg_i.shift[2]};
    end else if (off_new >= cfg_i.start[1]) begin
      remapped = off_ext + {9'd0, cfg_i.shift[1]};
    end else if (off_new >= cfg_i.start[0]) begin
      remapped = off_ext + {9'd0, cfg_i.shift[0]};
    end else begin
      remapped = off_ext;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    off_d     = off_q;
    addr_d    = addr_q;
    left_d    = left_q;
    fill_d    = fill_q;
    done_d    = done_q;
    res_vld_o = 1'b0;
    res_o     = '0;

    if (en_i) begin
      if (!done_q) begin
        case (phase_q)
          ipsp_pkg::PH_HEADER: begin
            if (hdr_idx_q >= ipsp_pkg::HDR_LEN || byte_i != ipsp_pkg::hdr_char(hdr_idx_q)) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_BADHDR;
              done_d     = 1'b1;
            end else begin
              hdr_idx_d = hdr_idx_inc;
              if (hdr_idx_inc == ipsp_pkg::HDR_LEN) begin
                phase_d = ipsp_pkg::PH_OFF0;
              end else if (last_i) begin
                res_vld_o  = 1'b1;
                res_o.kind = ipsp_pkg::K_BADHDR;
              end
            end
          end
          ipsp_pkg::PH_OFF0: begin
            off_d   = {byte_i, 16'd0};
            phase_d = ipsp_pkg::PH_OFF1;
            if (last_i) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_TRUNC;
            end
          end
          ipsp_pkg::PH_OFF1: begin
            off_d   = {off_q[23:16], byte_i, 8'd0};
            phase_d = ipsp_pkg::PH_OFF2;
            if (last_i) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_TRUNC;
            end
          end
          ipsp_pkg::PH_OFF2: begin
            off_d = off_new;
            if (off_new == ipsp_pkg::EOF_MARK) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_END;
              done_d     = 1'b1;
            end else begin
              addr_d  = remapped;
              phase_d = ipsp_pkg::PH_SIZE0;
              if (last_i) begin
                res_vld_o  = 1'b1;
                res_o.kind = ipsp_pkg::K_TRUNC;
              end
            end
          end
          ipsp_pkg::PH_SIZE0: begin
            left_d  = {byte_i, 8'd0};
            phase_d = ipsp_pkg::PH_SIZE1;
            if (last_i) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_TRUNC;
            end
          end
          ipsp_pkg::PH_SIZE1: begin
            left_d  = {left_q[15:8], byte_i};
            phase_d = ({left_q[15:8], byte_i} != 16'd0) ? ipsp_pkg::PH_DATA
                                                        : ipsp_pkg::PH_RLEN0;
            if (last_i) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_TRUNC;
            end
          end
          ipsp_pkg::PH_DATA: begin
            if (last_i && left_q > 16'd1) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_TRUNC;
            end else begin
              res_vld_o   = 1'b1;
              res_o.kind  = ipsp_pkg::K_WRITE;
              res_o.addr  = addr_q;
              res_o.value = byte_i;
              res_o.len   = 16'd1;
              addr_d      = addr_q + 25'd1;
              left_d      = left_dec;
              if (left_dec == 16'd0) begin
                phase_d = ipsp_pkg::PH_OFF0;
              end
            end
          end
          ipsp_pkg::PH_RLEN0: begin
            fill_d  = {byte_i, 8'd0};
            phase_d = ipsp_pkg::PH_RLEN1;
            if (last_i) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_TRUNC;
            end
          end
          ipsp_pkg::PH_RLEN1: begin
            fill_d  = {fill_q[15:8], byte_i};
            phase_d = ipsp_pkg::PH_RVAL;
            if (last_i) begin
              res_vld_o  = 1'b1;
              res_o.kind = ipsp_pkg::K_TRUNC;
            end
          end
          ipsp_pkg::PH_RVAL: begin
            // A zero run length consumes the fill byte silently.
            if (fill_q != 16'd0) begin
              res_vld_o   = 1'b1;
              res_o.kind  = ipsp_pkg::K_FILL;
              res_o.addr  = addr_q;
              res_o.value = byte_i;
              res_o.len   = fill_q;
            end
            phase_d = ipsp_pkg::PH_OFF0;
          end
          default: begin
            phase_d = ipsp_pkg::PH_HEADER;
          end
        endcase
      end

      // The last byte of a stream always rearms the parser for a new header.
      if (last_i) begin
        phase_d   = ipsp_pkg::PH_HEADER;
        hdr_idx_d = 3'd0;
        off_d     = '0;
        addr_d    = '0;
        left_d    = '0;
        fill_d    = '0;
        done_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ipsp_pkg::PH_HEADER;
      hdr_idx_q <= 3'd0;
      off_q     <= '0;
      addr_q    <= '0;
      left_q    <= '0;
      fill_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      off_q     <= off_d;
      addr_q    <= addr_d;
      left_q    <= left_d;
      fill_q    <= fill_d;
      done_q    <= done_d;
    end
  end

`ifndef ASSERT_OFF
  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && last_i |=> phase_q == ipsp_pkg::PH_HEADER && hdr_idx_q == 3'd0 && !done_q)
    else $error("parser did not rearm after the last byte");

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ipsp_pkg::PH_DATA |-> left_q != 16'd0)
    else $error("data phase entered with no bytes left");

  a_write_len_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.kind == ipsp_pkg::K_WRITE |-> res_o.len == 16'd1)
    else $error("byte write with run length other than one");

  a_hdr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_idx_q <= ipsp_pkg::HDR_LEN)
    else $error("header index beyond header length");

  a_silent_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !res_vld_o)
    else $error("result produced after the stream was closed");
`endif

endmodule

`default_nettype wire

// File: sv/ipsp_out_stage.sv
// Result register driving the master stream side.
// Depends on ipsp_pkg.
`default_nettype none

module ipsp_out_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  ipsp_pkg::result_t                  res_i,
  output      logic                          space_o,
  output      logic                          valid_o,
  input  wire logic                          ready_i,
  output      logic [ipsp_pkg::OutDataW-1:0] data_o,
  output      logic [ipsp_pkg::KindW-1:0]    kind_o
);

  logic              valid_q, valid_d;
  ipsp_pkg::result_t res_q;

  // A waiting result that is taken this cycle frees the register for the next.
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = res_q.kind;
  assign data_o  = {7'd0, res_q.len, res_q.value, res_q.addr};

endmodule

`default_nettype wire

// File: sv/ips_patch_stream_parser_core.sv
// Path: input register, combinational parser, result register, then the master side.
// Throughput: one patch byte per cycle while the master side keeps up, at most one
// result per byte; input and result registers each hand over in the cycle they empty.
// Reset (rst_ni, asynchronous, active low) empties both registers, rearms the parser
// for the header and loads the region registers with their default values.
// Top level of the IPS patch stream parser; depends on ipsp_pkg and its submodules.
`default_nettype none

module ips_patch_stream_parser_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [ipsp_pkg::ByteW-1:0]    s_axis_tdata,  // [7:0] patch_byte
  input  wire logic                          s_axis_tlast,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [24:0] target_address, [32:25] write_value, [48:33] run_length, [55:49] zero
  output      logic [ipsp_pkg::OutDataW-1:0] m_axis_tdata,
  output      logic [ipsp_pkg::KindW-1:0]    m_axis_tuser,  // [2:0] result_kind
  input  wire logic                          cfg_we_i,
  input  wire logic [ipsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ipsp_pkg::CfgDataW-1:0] cfg_data_i
);

  ipsp_pkg::cfg_t             cfg;
  ipsp_pkg::result_t          res;
  logic                       res_vld;
  logic                       in_valid;
  logic [ipsp_pkg::ByteW-1:0] in_byte;
  logic                       in_last;
  logic                       out_space;
  logic                       advance;

  assign advance = in_valid && out_space;

  ipsp_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ipsp_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .byte_i    (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .last_o    (in_last)
  );

  ipsp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .byte_i    (in_byte),
    .last_i    (in_last),
    .cfg_i     (cfg),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  ipsp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_vld),
    .res_i   (res),
    .space_o (out_space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .kind_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
